/* hdl/lpfc_pkg.sv */
// shared types and constants for the led panel frame controller
`timescale 1ns / 1ps

package lpfc_pkg;

  localparam int PanelSide = 16;
  localparam int SideBits  = 4;
  localparam int WordCount = 16;

  // operation codes carried by an input transfer
  typedef enum logic [2:0] {
    OP_WRITE_PIXEL   = 3'd0,
    OP_DRAW_LINE     = 3'd1,
    OP_ROTATE        = 3'd2,
    OP_CLEAR_REFRESH = 3'd3,
    OP_REFRESH       = 3'd4
  } opcode_e;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_REFRESH
  } ctrl_state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic                write_pixel;
    logic                draw_line;
    logic                rotate;
    logic                clear;
    logic                emit;
    logic                last;
    logic [SideBits-1:0] word_idx;
  } ctrl_cmd_t;

endpackage

/* hdl/led_panel_frame_controller.sv */
// top level of the 16x16 led panel frame controller
`timescale 1ns / 1ps
//
// Keeps a 16x16 one-bit frame and sends it out in the panel's wiring order.
// Command channel: an operation transfers at a rising edge with start_i high
// and busy_o low. Pixel write, line draw and quarter turn give no result;
// a new command may follow in the next cycle. Refresh and clear-and-refresh
// raise busy_o while the word counter in the controller paces out the
// shift words, one per counter step. The words come out on shift_word_o in
// the cycle after each counter step, each for exactly one cycle with
// strobe_o high; the sixteenth carries latch_o. The next command is taken
// in the cycle that shows the last word.
// rotation_quarters_o gives the quarter count at the time of the refresh.
// The receiver cannot stall: each word must be taken in its strobe cycle.
// Reset (rst_ni low, asynchronous) darkens the frame, zeroes the count and
// returns the controller to idle.
//
module led_panel_frame_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [2:0]        opcode_i,
  input  logic [3:0]        pixel_x_i,
  input  logic [3:0]        pixel_y_i,
  input  logic [7:0]        pixel_value_i,
  input  logic [3:0]        line_index_i,
  input  logic              line_is_column_i,
  input  logic              turn_right_i,
  output logic              strobe_o,
  output logic [15:0]       shift_word_o,
  output logic              latch_o,
  output logic signed [2:0] rotation_quarters_o
);
  import lpfc_pkg::*;

  ctrl_cmd_t cmd;

  // controller
  lpfc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .busy_o   (busy_o),
    .cmd_o    (cmd)
  );

  // datapath
  lpfc_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .pixel_x_i           (pixel_x_i),
    .pixel_y_i           (pixel_y_i),
    .pixel_value_i       (pixel_value_i),
    .line_index_i        (line_index_i),
    .line_is_column_i    (line_is_column_i),
    .turn_right_i        (turn_right_i),
    .shift_word_o        (shift_word_o),
    .latch_o             (latch_o),
    .rotation_quarters_o (rotation_quarters_o),
    .strobe_o            (strobe_o)
  );

endmodule

/* hdl/lpfc_ctrl.sv */
// controller state machine: operation decode and refresh word sequencing
`timescale 1ns / 1ps

module lpfc_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [2:0]               opcode_i,
  output logic                     busy_o,
  output lpfc_pkg::ctrl_cmd_t      cmd_o
);
  import lpfc_pkg::*;

  ctrl_state_e         state_q, state_d;
  logic [SideBits-1:0] word_q, word_d;
  logic                accept;
  logic                refresh_req;

  assign accept = start_i && (state_q == ST_IDLE);

  // refresh request decode
  always_comb begin
    refresh_req = 1'b0;
    unique case (opcode_i)
      OP_CLEAR_REFRESH, OP_REFRESH: refresh_req = 1'b1;
      default:                      refresh_req = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    word_d  = word_q;
    unique case (state_q)
      ST_IDLE: begin
        word_d = '0;
        if (accept && refresh_req) begin
          state_d = ST_REFRESH;
        end
      end
      ST_REFRESH: begin
        word_d = word_q + 1'b1;
        if (word_q == SideBits'(WordCount - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.word_idx = word_q;
    busy_o         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (opcode_i)
            OP_WRITE_PIXEL:   cmd_o.write_pixel = 1'b1;
            OP_DRAW_LINE:     cmd_o.draw_line   = 1'b1;
            OP_ROTATE:        cmd_o.rotate      = 1'b1;
            OP_CLEAR_REFRESH: cmd_o.clear       = 1'b1;
            default:          cmd_o.clear       = 1'b0;
          endcase
        end
      end
      ST_REFRESH: begin
        busy_o     = 1'b1;
        cmd_o.emit = 1'b1;
        cmd_o.last = (word_q == SideBits'(WordCount - 1));
      end
      default: busy_o = 1'b0;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      word_q  <= '0;
    end else begin
      state_q <= state_d;
      word_q  <= word_d;
    end
  end

endmodule

/* hdl/lpfc_datapath.sv */
// frame store, rotation counter and shift word output register
`timescale 1ns / 1ps

module lpfc_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lpfc_pkg::ctrl_cmd_t        cmd_i,
  input  logic [3:0]                 pixel_x_i,
  input  logic [3:0]                 pixel_y_i,
  input  logic [7:0]                 pixel_value_i,
  input  logic [3:0]                 line_index_i,
  input  logic                       line_is_column_i,
  input  logic                       turn_right_i,
  output logic [15:0]                shift_word_o,
  output logic                       latch_o,
  output logic signed [2:0]          rotation_quarters_o,
  output logic                       strobe_o
);
  import lpfc_pkg::*;

  // frame rows indexed by y, bits by x
  logic [PanelSide-1:0][PanelSide-1:0] frame_q, frame_d;
  logic signed [2:0]                   rot_q, rot_d;
  logic signed [3:0]                   rot_sum;
  logic [15:0]                         shift_word_q, word_d;
  logic                                latch_q;
  logic signed [2:0]                   rot_out_q;
  logic                                strobe_q;
  logic [2:0]                          pair;
  logic                                half;
  logic [PanelSide-1:0]                row_even, row_odd;

  // frame update: clear, pixel write, line draw, quarter turn
  always_comb begin
    frame_d = frame_q;
    if (cmd_i.clear) begin
      frame_d = '0;
    end
    if (cmd_i.write_pixel) begin
      frame_d[pixel_y_i][pixel_x_i] = |pixel_value_i;
    end
    if (cmd_i.draw_line) begin
      if (line_is_column_i) begin
        for (int r = 0; r < PanelSide; r++) begin
          frame_d[r][line_index_i] = 1'b1;
        end
      end else begin
        frame_d[line_index_i] = '1;
      end
    end
    if (cmd_i.rotate) begin
      for (int r = 0; r < PanelSide; r++) begin
        for (int c = 0; c < PanelSide; c++) begin
          if (turn_right_i) begin
            frame_d[r][c] = frame_q[c][PanelSide - 1 - r];
          end else begin
            frame_d[r][c] = frame_q[PanelSide - 1 - c][r];
          end
        end
      end
    end
  end

  // quarter count wraps to zero at plus or minus four
  always_comb begin
    rot_sum = {rot_q[2], rot_q} + (turn_right_i ? 4'sd1 : -4'sd1);
    rot_d   = rot_q;
    if (cmd_i.rotate) begin
      if (rot_sum == 4'sd4 || rot_sum == -4'sd4) begin
        rot_d = '0;
      end else begin
        rot_d = rot_sum[2:0];
      end
    end
  end

  // wiring order: word w takes one half of the rows of pair w/2
  assign pair     = cmd_i.word_idx[3:1];
  assign half     = pair[0] ? cmd_i.word_idx[0] : ~cmd_i.word_idx[0];
  assign row_even = frame_q[{pair, 1'b0}];
  assign row_odd  = frame_q[{pair, 1'b1}];

  always_comb begin
    word_d = '0;
    for (int i = 0; i < 8; i++) begin
      word_d[i]     = row_even[{half, 3'(7 - i)}];
      word_d[8 + i] = row_odd[{half, 3'(i)}];
    end
  end

  // frame and rotation state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      rot_q   <= '0;
    end else begin
      frame_q <= frame_d;
      rot_q   <= rot_d;
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      shift_word_q <= word_d;
      latch_q      <= cmd_i.last;
      rot_out_q    <= rot_q;
    end
  end

  assign shift_word_o        = shift_word_q;
  assign latch_o             = latch_q;
  assign rotation_quarters_o = rot_out_q;
  assign strobe_o            = strobe_q;

endmodule
